[src/fssb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fssb_pkg
// Shared constants, types and codes of the frame store with scaled blitter.
// ----------------------------------------------------------------------------
package fssb_pkg;

  localparam int unsigned FRAME_PIXELS = 65536;
  localparam int unsigned PIXEL_BITS   = 24;
  localparam int unsigned ADDR_W       = $clog2(FRAME_PIXELS);
  localparam int unsigned LIN_W        = 23;
  localparam int unsigned COORD_W      = 16;
  localparam int unsigned MAX_STEP     = 8;

  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [PIXEL_BITS-1:0] pixel_t;
  typedef logic [23:0]           pix_field_t;
  typedef logic [LIN_W-1:0]      lin_t;
  typedef logic [COORD_W-1:0]    coord_t;

  typedef enum logic [1:0] {
    ACT_BLIT_WR = 2'd0,
    ACT_BLIT_RD = 2'd1,
    ACT_IDX_RD  = 2'd2,
    ACT_IDX_WR  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    REG_SCREEN_W = 3'd0,
    REG_SCREEN_H = 3'd1,
    REG_IMAGE_W  = 3'd2,
    REG_IMAGE_H  = 3'd3,
    REG_ORIGIN_X = 3'd4,
    REG_ORIGIN_Y = 3'd5,
    REG_STEP     = 3'd6
  } reg_e;

  localparam logic [10:0] SCREEN_W_RST = 11'd320;
  localparam logic [10:0] SCREEN_H_RST = 11'd240;
  localparam logic [3:0]  STEP_RST     = 4'd1;

endpackage

[src/frame_store_scaled_blitter.sv]
`timescale 1ns / 1ps
// One item at a time; the next is taken the cycle after the result is
// registered. A blit write goes through the single frame store port, which
// writes one screen pixel a cycle while in its cell state, with a row setup
// state between rows; the step is clamped to 8. Reset clears the counters and
// the registers to their defaults; frame store contents are undefined.
// ----------------------------------------------------------------------------
// frame_store_scaled_blitter
// Frame store with a scaled, clipped rectangle blitter and indexed access.
// ----------------------------------------------------------------------------
module frame_store_scaled_blitter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // pixel_value[23:0], screen_index[39:24]
  input  logic [1:0]  s_axis_tuser,   // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // pixel_out[23:0], in_bounds[24],
                                      // pixels_written[31:25]
  output logic        m_axis_tlast,   // blit_done
  output logic        m_axis_tuser    // status
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_ROW, ST_CELL, ST_SREAD, ST_SWAIT, ST_ADV, ST_IDX, ST_IWAIT, ST_RESP
  } state_e;

  state_e state_q, state_d;

  logic [10:0] sw_q, sh_q;
  logic [11:0] iw_q, ih_q, ox_q, oy_q;
  logic [3:0]  step_cfg_q;

  fssb_pkg::action_e action_q, action_in;
  fssb_pkg::pixel_t  pix_q;
  logic [15:0]       sidx_q;
  fssb_pkg::coord_t  bx_q, by_q, bx_d, by_d, x_cur, y_cur;
  logic [3:0]        step_q, step_eff;
  logic [2:0]        r_q, c_q, s_m1;
  logic              y_ok_q, y_ok, hit_q;
  logic [21:0]       row_base_q, row_prod, area;
  fssb_pkg::lin_t    lin;
  logic              cell_in, idx_ok, rect_empty, accept, out_load;
  logic [11:0]       col_q, line_q, col_inc, line_inc;
  logic              col_wrap, line_wrap;

  logic [23:0] res_pix_q;
  logic        res_inb_q, res_done_q, res_status_q;
  logic [6:0]  res_wr_q;

  logic        m_tvalid_q, m_tlast_q, m_tuser_q;
  logic [31:0] m_tdata_q;

  logic              ram_we;
  fssb_pkg::addr_t   ram_addr;
  fssb_pkg::pixel_t  ram_rdata;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q       <= fssb_pkg::SCREEN_W_RST;
      sh_q       <= fssb_pkg::SCREEN_H_RST;
      iw_q       <= '0;
      ih_q       <= '0;
      ox_q       <= '0;
      oy_q       <= '0;
      step_cfg_q <= fssb_pkg::STEP_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        fssb_pkg::REG_SCREEN_W: sw_q       <= cfg_data_i[10:0];
        fssb_pkg::REG_SCREEN_H: sh_q       <= cfg_data_i[10:0];
        fssb_pkg::REG_IMAGE_W:  iw_q       <= cfg_data_i;
        fssb_pkg::REG_IMAGE_H:  ih_q       <= cfg_data_i;
        fssb_pkg::REG_ORIGIN_X: ox_q       <= cfg_data_i;
        fssb_pkg::REG_ORIGIN_Y: oy_q       <= cfg_data_i;
        fssb_pkg::REG_STEP:     step_cfg_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Datapath
  assign action_in  = fssb_pkg::action_e'(s_axis_tuser);
  assign accept     = s_axis_tvalid && s_axis_tready;
  assign step_eff   = (step_cfg_q > 4'(fssb_pkg::MAX_STEP)) ? 4'(fssb_pkg::MAX_STEP)
                                                            : step_cfg_q;
  assign rect_empty = (iw_q == '0) || (ih_q == '0);
  assign bx_d       = {4'b0, ox_q} + ({12'b0, step_eff} * {4'b0, col_q});
  assign by_d       = {4'b0, oy_q} + ({12'b0, step_eff} * {4'b0, line_q});
  assign s_m1       = 3'(step_q - 4'd1);

  assign y_cur    = by_q + fssb_pkg::coord_t'(r_q);
  assign y_ok     = y_cur < {5'b0, sh_q};
  assign row_prod = 22'(y_cur[10:0]) * 22'(sw_q);
  assign x_cur    = bx_q + fssb_pkg::coord_t'(c_q);
  assign lin      = fssb_pkg::lin_t'(row_base_q) + fssb_pkg::lin_t'(x_cur);
  assign cell_in  = y_ok_q && (x_cur < {5'b0, sw_q})
                 && (lin < fssb_pkg::lin_t'(fssb_pkg::FRAME_PIXELS));

  assign area   = 22'(sw_q) * 22'(sh_q);
  assign idx_ok = ({6'b0, sidx_q} < area)
               && (fssb_pkg::lin_t'(sidx_q) < fssb_pkg::lin_t'(fssb_pkg::FRAME_PIXELS));

  assign col_inc   = col_q + 12'd1;
  assign col_wrap  = (col_inc >= iw_q) || (col_inc == '0);
  assign line_inc  = line_q + 12'd1;
  assign line_wrap = (line_inc >= ih_q) || (line_inc == '0);

  assign out_load = (state_q == ST_RESP) && (!m_tvalid_q || m_axis_tready);

  always_comb begin
    ram_we   = 1'b0;
    ram_addr = fssb_pkg::addr_t'(lin);
    case (state_q)
      ST_CELL: ram_we = cell_in;
      ST_IDX: begin
        ram_addr = fssb_pkg::addr_t'(sidx_q);
        ram_we   = idx_ok && (action_q == fssb_pkg::ACT_IDX_WR);
      end
      default: ;
    endcase
  end

  fssb_ram #(
    .WIDTH (fssb_pkg::PIXEL_BITS),
    .DEPTH (fssb_pkg::FRAME_PIXELS)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (pix_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (action_in == fssb_pkg::ACT_BLIT_WR || action_in == fssb_pkg::ACT_BLIT_RD) begin
            if (rect_empty) begin
              state_d = ST_RESP;
            end else if (action_in == fssb_pkg::ACT_BLIT_WR && step_eff == '0) begin
              state_d = ST_ADV;
            end else begin
              state_d = ST_ROW;
            end
          end else begin
            state_d = ST_IDX;
          end
        end
      end
      ST_ROW:   state_d = (action_q == fssb_pkg::ACT_BLIT_WR) ? ST_CELL : ST_SREAD;
      ST_CELL: begin
        if (c_q == s_m1) begin
          state_d = (r_q == s_m1) ? ST_ADV : ST_ROW;
        end
      end
      ST_SREAD: state_d = ST_SWAIT;
      ST_SWAIT: state_d = ST_ADV;
      ST_ADV:   state_d = ST_RESP;
      ST_IDX:   state_d = (action_q == fssb_pkg::ACT_IDX_RD) ? ST_IWAIT : ST_RESP;
      ST_IWAIT: state_d = ST_RESP;
      ST_RESP: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      col_q        <= '0;
      line_q       <= '0;
      m_tvalid_q   <= 1'b0;
      action_q     <= fssb_pkg::ACT_BLIT_WR;
      pix_q        <= '0;
      sidx_q       <= '0;
      bx_q         <= '0;
      by_q         <= '0;
      step_q       <= '0;
      r_q          <= '0;
      c_q          <= '0;
      y_ok_q       <= 1'b0;
      row_base_q   <= '0;
      hit_q        <= 1'b0;
      res_pix_q    <= '0;
      res_inb_q    <= 1'b0;
      res_wr_q     <= '0;
      res_done_q   <= 1'b0;
      res_status_q <= 1'b0;
      m_tdata_q    <= '0;
      m_tlast_q    <= 1'b0;
      m_tuser_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            action_q     <= action_in;
            pix_q        <= fssb_pkg::pixel_t'(s_axis_tdata[23:0]);
            sidx_q       <= s_axis_tdata[39:24];
            bx_q         <= bx_d;
            by_q         <= by_d;
            step_q       <= step_eff;
            r_q          <= '0;
            c_q          <= '0;
            res_pix_q    <= '0;
            res_inb_q    <= 1'b0;
            res_wr_q     <= '0;
            res_done_q   <= 1'b0;
            res_status_q <= rect_empty && (action_in == fssb_pkg::ACT_BLIT_WR
                                        || action_in == fssb_pkg::ACT_BLIT_RD);
          end
        end
        ST_ROW: begin
          y_ok_q     <= y_ok;
          row_base_q <= y_ok ? row_prod : '0;
          c_q        <= '0;
        end
        ST_CELL: begin
          res_wr_q <= res_wr_q + 7'(cell_in);
          if (c_q == s_m1) begin
            r_q <= r_q + 3'd1;
          end else begin
            c_q <= c_q + 3'd1;
          end
        end
        ST_SREAD: hit_q <= cell_in;
        ST_SWAIT: begin
          res_pix_q <= hit_q ? fssb_pkg::pix_field_t'(ram_rdata) : '0;
          res_inb_q <= hit_q;
        end
        ST_ADV: begin
          if (col_wrap) begin
            col_q <= '0;
            if (line_wrap) begin
              line_q     <= '0;
              res_done_q <= 1'b1;
            end else begin
              line_q <= line_inc;
            end
          end else begin
            col_q <= col_inc;
          end
        end
        ST_IDX: begin
          hit_q     <= idx_ok;
          res_inb_q <= idx_ok;
          if (action_q == fssb_pkg::ACT_IDX_WR) begin
            res_wr_q <= 7'(idx_ok);
          end
        end
        ST_IWAIT: res_pix_q <= hit_q ? fssb_pkg::pix_field_t'(ram_rdata) : '0;
        default: ;
      endcase

      if (out_load) begin
        m_tvalid_q <= 1'b1;
        m_tdata_q  <= {res_wr_q, res_inb_q, res_pix_q};
        m_tlast_q  <= res_done_q;
        m_tuser_q  <= res_status_q;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tlast  = m_tlast_q;
  assign m_axis_tuser  = m_tuser_q;

endmodule

[src/fssb_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fssb_ram
// Single-port synchronous RAM, one access per cycle, registered read that returns the old data on a write.
// ----------------------------------------------------------------------------
module fssb_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/fssb_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fssb_checker
// Port-level checks of the frame store blitter, bound to the top level.
// ----------------------------------------------------------------------------
module fssb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  // One item in flight: no second item straight after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted in the cycle after an accept");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("stalled output item changed");

  a_reject_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0 && !m_axis_tlast)
    else $error("rejected item carries data");

  a_black_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[24] |-> m_axis_tdata[23:0] == '0)
    else $error("pixel returned outside the screen");

  a_write_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[31:25] <= 7'd64)
    else $error("written pixel count above a full block");

endmodule

bind frame_store_scaled_blitter fssb_checker u_fssb_checker (.*);
